// ===== design/midi_track_event_parser_core_macros.svh =====
// Assertion macros used by the checker file of the track parser.
`ifndef MIDI_TRACK_EVENT_PARSER_CORE_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define MTEP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("track parser check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("track parser check failed");

`endif

// ===== design/mtep_pkg.sv =====
// Types and constants of the MIDI track event parser.
package mtep_pkg;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_DELTA,
      PH_STATUS,
      PH_DATA1,
      PH_DATA2,
      PH_META_TYPE,
      PH_META_LEN,
      PH_META_BODY,
      PH_SYSEX_LEN,
      PH_SYSEX_BODY
   } phase_type;

   localparam logic [2:0] KIND_EVENT      = 3'd0;
   localparam logic [2:0] KIND_LEN_END    = 3'd1;
   localparam logic [2:0] KIND_END_TRACK  = 3'd2;
   localparam logic [2:0] KIND_BAD_HEADER = 3'd3;
   localparam logic [2:0] KIND_ORPHAN     = 3'd4;
   localparam logic [2:0] KIND_EMPTY      = 3'd5;

   localparam logic [7:0] MARK_M = 8'h4d;
   localparam logic [7:0] MARK_T = 8'h54;
   localparam logic [7:0] MARK_R = 8'h72;
   localparam logic [7:0] MARK_K = 8'h6b;

   localparam logic [7:0] STATUS_META    = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
   localparam logic [7:0] META_END_TRACK = 8'h2F;
   localparam logic [7:0] META_TIME_SIG  = 8'h58;
   localparam logic [7:0] META_KEY_SIG   = 8'h59;
   localparam logic [7:0] MSG_PROGRAM    = 8'hC0;
   localparam logic [7:0] MSG_PRESSURE   = 8'hD0;

   function automatic logic [7:0] marker_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0: m = MARK_M;
         2'd1: m = MARK_T;
         2'd2: m = MARK_R;
         default: m = MARK_K;
      endcase
      return m;
   endfunction

   // Program change and channel pressure carry a single data byte.
   function automatic logic one_data_byte(input logic [7:0] status);
      return (status[7:4] == MSG_PROGRAM[7:4]) || (status[7:4] == MSG_PRESSURE[7:4]);
   endfunction

endpackage

// ===== design/midi_track_event_parser_core.sv =====
// Standard MIDI File track parser: one stream byte in, at most one event record out.
//
//   channel   direction   payload                         handshake
//   req_      in          track_byte                      req_valid / req_ready
//   rsp_      out         record kind, delta, status,     rsp_valid / rsp_ready
//                         sticky meta and signature bytes
//
// One byte is taken every cycle while no record waits untaken; the parser state and the result
// register are both written at the edge that accepts the byte, so a record shows in the following cycle.
// The result register holds a record until it is taken; a byte is still accepted
// while a record waits if rsp_ready is high in that cycle.
// Reset is synchronous and returns the parser to header hunting with all sticky bytes zero.
module midi_track_event_parser_core
   import mtep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_track_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_record_kind,
   output logic [31:0] rsp_delta_time,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_meta_type,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data,
   output logic [7:0]  rsp_key_sharps,
   output logic [7:0]  rsp_key_minor,
   output logic [7:0]  rsp_time_numerator,
   output logic [7:0]  rsp_time_denominator_log2,
   output logic [7:0]  rsp_clocks_per_click,
   output logic [7:0]  rsp_thirty_seconds_per_quarter
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  header_index_ff, header_index_in;
   logic [31:0] track_length_ff, track_length_in;
   logic [31:0] bytes_consumed_ff, bytes_consumed_in;
   logic [31:0] delta_ff, delta_in;
   logic [31:0] body_length_ff, body_length_in;
   logic [31:0] body_index_ff, body_index_in;
   logic [7:0]  running_status_ff, running_status_in;
   logic [7:0]  current_status_ff, current_status_in;
   logic [7:0]  meta_type_ff, meta_type_in;
   logic [7:0]  first_data_ff, first_data_in;
   logic [7:0]  second_data_ff, second_data_in;
   logic [7:0]  key_ff [2];
   logic [7:0]  key_in [2];
   logic [7:0]  time_ff [4];
   logic [7:0]  time_in [4];

   logic        emit;
   logic [2:0]  emit_kind;
   logic [31:0] emit_delta;
   logic [7:0]  emit_status;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [31:0] rsp_delta_ff;
   logic [7:0]  rsp_status_ff;
   logic [7:0]  rsp_meta_ff, rsp_first_ff, rsp_second_ff;
   logic [7:0]  rsp_key_ff [2];
   logic [7:0]  rsp_time_ff [4];

   logic        accept;
   logic [7:0]  b;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_track_byte;

   always_comb begin
      logic       finish;
      logic [3:0] idx_next;
      finish            = 1'b0;
      idx_next          = {1'b0, header_index_ff} + 4'd1;
      phase_in          = phase_ff;
      header_index_in   = header_index_ff;
      track_length_in   = track_length_ff;
      bytes_consumed_in = bytes_consumed_ff;
      delta_in          = delta_ff;
      body_length_in    = body_length_ff;
      body_index_in     = body_index_ff;
      running_status_in = running_status_ff;
      current_status_in = current_status_ff;
      meta_type_in      = meta_type_ff;
      first_data_in     = first_data_ff;
      second_data_in    = second_data_ff;
      key_in            = key_ff;
      time_in           = time_ff;
      emit              = 1'b0;
      emit_kind         = KIND_EVENT;
      emit_delta        = '0;
      emit_status       = '0;

      if (phase_ff == PH_HUNT) begin
         if (!header_index_ff[2]) begin
            if (b == marker_byte(header_index_ff[1:0])) begin
               header_index_in = idx_next[2:0];
            end else begin
               header_index_in = (b == MARK_M) ? 3'd1 : 3'd0;
               emit            = 1'b1;
               emit_kind       = KIND_BAD_HEADER;
            end
         end else begin
            track_length_in = {track_length_ff[23:0], b};
            header_index_in = idx_next[2:0];
            if (idx_next[3]) begin
               if (track_length_in == '0) begin
                  emit      = 1'b1;
                  emit_kind = KIND_EMPTY;
               end else begin
                  phase_in          = PH_DELTA;
                  bytes_consumed_in = '0;
                  delta_in          = '0;
                  running_status_in = '0;
                  current_status_in = '0;
               end
            end
         end
      end else begin
         if (bytes_consumed_ff != '1) begin
            bytes_consumed_in = bytes_consumed_ff + 32'd1;
         end
         case (phase_ff)
            PH_DELTA: begin
               delta_in = {delta_ff[24:0], b[6:0]};
               if (!b[7]) begin
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (b == STATUS_META) begin
                  current_status_in = b;
                  phase_in          = PH_META_TYPE;
               end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
                  current_status_in = b;
                  body_length_in    = '0;
                  phase_in          = PH_SYSEX_LEN;
               end else if (b[7] && b < STATUS_SYSEX) begin
                  current_status_in = b;
                  running_status_in = b;
                  phase_in          = PH_DATA1;
               end else if (!b[7] && running_status_ff != '0) begin
                  current_status_in = running_status_ff;
                  first_data_in     = b;
                  if (one_data_byte(running_status_ff)) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_DATA2;
                  end
               end else begin
                  // Stray system status or data with nothing to run on.
                  emit            = 1'b1;
                  emit_kind       = KIND_ORPHAN;
                  emit_delta      = delta_ff;
                  phase_in        = PH_HUNT;
                  header_index_in = '0;
               end
            end
            PH_DATA1: begin
               first_data_in = b;
               if (one_data_byte(current_status_ff)) begin
                  finish = 1'b1;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               second_data_in = b;
               finish         = 1'b1;
            end
            PH_META_TYPE: begin
               meta_type_in   = b;
               body_length_in = '0;
               phase_in       = PH_META_LEN;
            end
            PH_META_LEN: begin
               body_length_in = {body_length_ff[24:0], b[6:0]};
               if (!b[7]) begin
                  if (meta_type_ff == META_END_TRACK) begin
                     emit            = 1'b1;
                     emit_kind       = KIND_END_TRACK;
                     emit_delta      = delta_ff;
                     emit_status     = current_status_ff;
                     phase_in        = PH_HUNT;
                     header_index_in = '0;
                  end else begin
                     body_index_in = '0;
                     if (body_length_in == '0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = PH_META_BODY;
                     end
                  end
               end
            end
            PH_META_BODY: begin
               if (meta_type_ff == META_TIME_SIG && body_index_ff < 32'd4) begin
                  time_in[body_index_ff[1:0]] = b;
               end else if (meta_type_ff == META_KEY_SIG && body_index_ff < 32'd2) begin
                  key_in[body_index_ff[0]] = b;
               end
               body_index_in = body_index_ff + 32'd1;
               if (body_index_in >= body_length_ff) begin
                  finish = 1'b1;
               end
            end
            PH_SYSEX_LEN: begin
               body_length_in = {body_length_ff[24:0], b[6:0]};
               if (!b[7]) begin
                  body_index_in = '0;
                  if (body_length_in == '0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_SYSEX_BODY;
                  end
               end
            end
            PH_SYSEX_BODY: begin
               body_index_in = body_index_ff + 32'd1;
               if (body_index_in >= body_length_ff) begin
                  finish = 1'b1;
               end
            end
            default: begin
               phase_in        = PH_HUNT;
               header_index_in = '0;
            end
         endcase

         if (finish) begin
            emit        = 1'b1;
            emit_delta  = delta_ff;
            emit_status = current_status_in;
            if (bytes_consumed_in >= track_length_ff) begin
               emit_kind       = KIND_LEN_END;
               phase_in        = PH_HUNT;
               header_index_in = '0;
            end else begin
               emit_kind = KIND_EVENT;
               phase_in  = PH_DELTA;
               delta_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         header_index_ff   <= '0;
         track_length_ff   <= '0;
         bytes_consumed_ff <= '0;
         delta_ff          <= '0;
         body_length_ff    <= '0;
         body_index_ff     <= '0;
         running_status_ff <= '0;
         current_status_ff <= '0;
         meta_type_ff      <= '0;
         first_data_ff     <= '0;
         second_data_ff    <= '0;
         key_ff            <= '{default: '0};
         time_ff           <= '{default: '0};
      end else if (accept) begin
         phase_ff          <= phase_in;
         header_index_ff   <= header_index_in;
         track_length_ff   <= track_length_in;
         bytes_consumed_ff <= bytes_consumed_in;
         delta_ff          <= delta_in;
         body_length_ff    <= body_length_in;
         body_index_ff     <= body_index_in;
         running_status_ff <= running_status_in;
         current_status_ff <= current_status_in;
         meta_type_ff      <= meta_type_in;
         first_data_ff     <= first_data_in;
         second_data_ff    <= second_data_in;
         key_ff            <= key_in;
         time_ff           <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The sticky fields of a record show the values after this byte's update.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_delta_ff  <= emit_delta;
         rsp_status_ff <= emit_status;
         rsp_meta_ff   <= meta_type_in;
         rsp_first_ff  <= first_data_in;
         rsp_second_ff <= second_data_in;
         rsp_key_ff    <= key_in;
         rsp_time_ff   <= time_in;
      end
   end

   assign rsp_valid                      = rsp_valid_ff;
   assign rsp_record_kind                = rsp_kind_ff;
   assign rsp_delta_time                 = rsp_delta_ff;
   assign rsp_status_byte                = rsp_status_ff;
   assign rsp_meta_type                  = rsp_meta_ff;
   assign rsp_first_data                 = rsp_first_ff;
   assign rsp_second_data                = rsp_second_ff;
   assign rsp_key_sharps                 = rsp_key_ff[0];
   assign rsp_key_minor                  = rsp_key_ff[1];
   assign rsp_time_numerator             = rsp_time_ff[0];
   assign rsp_time_denominator_log2      = rsp_time_ff[1];
   assign rsp_clocks_per_click           = rsp_time_ff[2];
   assign rsp_thirty_seconds_per_quarter = rsp_time_ff[3];

endmodule

// ===== design/mtep_checker.sv =====
// Port-level checker for the track parser and its bind to the top level.
`include "midi_track_event_parser_core_macros.svh"

module mtep_checker
   import mtep_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_record_kind,
   input logic [31:0] rsp_delta_time,
   input logic [7:0]  rsp_status_byte
);

   logic        rsp_stall;
   logic [34:0] rsp_head;
   logic        header_kind;
   logic        orphan_kind;
   logic        no_status;
   logic        no_timing;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_head    = {rsp_record_kind, rsp_delta_time};
   assign header_kind = (rsp_record_kind == KIND_BAD_HEADER) || (rsp_record_kind == KIND_EMPTY);
   assign orphan_kind = rsp_record_kind == KIND_ORPHAN;
   assign no_status   = rsp_status_byte == '0;
   assign no_timing   = (rsp_delta_time == '0) && no_status;

   // A waiting word holds its kind and delta.
   `MTEP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_head))

   // Input is stalled only by a word that is not being taken.
   `MTEP_ASSERT_NOW(a_ready_stall, clock, reset, !req_ready, rsp_stall)

   `MTEP_ASSERT_NOW(a_kind_range, clock, reset, rsp_valid, rsp_record_kind <= KIND_EMPTY)

   // Header records carry no timing and no status.
   `MTEP_ASSERT_NOW(a_header_fields, clock, reset, rsp_valid && header_kind, no_timing)

   `MTEP_ASSERT_NOW(a_orphan_status, clock, reset, rsp_valid && orphan_kind, no_status)

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_record_kind (rsp_record_kind),
   .rsp_delta_time  (rsp_delta_time),
   .rsp_status_byte (rsp_status_byte)
);

// ===== test/midi_track_event_parser_core_tb.sv =====
// Self-checking testbench for the MIDI track event parser core.
`timescale 1ns / 100ps

module midi_track_event_parser_core_tb
   import mtep_pkg::*;
;

   localparam logic [7:0] NO_STATUS       = 8'h00;
   localparam logic [7:0] CHANNEL_LOW     = 8'h80;
   localparam logic [7:0] CHANNEL_HIGH    = 8'hEF;
   localparam logic [7:0] STRAY_LOW       = 8'hF1;
   localparam logic [7:0] STRAY_HIGH      = 8'hFE;
   localparam logic [7:0] META_TEMPO      = 8'h51;
   localparam logic [7:0] META_INSTRUMENT = 8'h04;
   localparam logic [31:0] TRACK_TAG      = {MARK_M, MARK_T, MARK_R, MARK_K};
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_WORDS  = 1850;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_track_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_record_kind;
   logic [31:0] rsp_delta_time;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_meta_type;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [7:0]  rsp_key_sharps;
   logic [7:0]  rsp_key_minor;
   logic [7:0]  rsp_time_numerator;
   logic [7:0]  rsp_time_denominator_log2;
   logic [7:0]  rsp_clocks_per_click;
   logic [7:0]  rsp_thirty_seconds_per_quarter;

   midi_track_event_parser_core dut (.*);

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] delta;
      logic [7:0]  status;
      logic [7:0]  meta;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [7:0]  sharps;
      logic [7:0]  minor;
      logic [7:0]  numer;
      logic [7:0]  denom_log2;
      logic [7:0]  clocks;
      logic [7:0]  thirty_seconds;
   } track_record_type;

   typedef logic [31:0] field_set_type [12];

   typedef struct {
      logic [7:0]  track_byte;
      bit          typed;
      logic [2:0]  kind;
      logic [31:0] delta;
      logic [7:0]  status;
   } directed_row_type;

   // Header hunting, the restart on a repeated 'M', an empty track, then a
   // track whose first delta overflows 32 bits and is followed by a data
   // byte with no running status.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00,  1'b1, KIND_BAD_HEADER, 32'h0, NO_STATUS},
      '{MARK_M, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{MARK_M, 1'b1, KIND_BAD_HEADER, 32'h0, NO_STATUS},
      '{MARK_T, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{MARK_R, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{MARK_K, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h00,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h00,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h00,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h00,  1'b1, KIND_EMPTY, 32'h0, NO_STATUS},
      '{MARK_M, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{MARK_T, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{MARK_R, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{MARK_K, 1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h00,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h00,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h00,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'hFF,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'hFF,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'hFF,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'hFF,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'hFF,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h7F,  1'b0, KIND_EVENT, 32'h0, NO_STATUS},
      '{8'h7F,  1'b1, KIND_ORPHAN, 32'hFFFF_FFFF, NO_STATUS}
   };

   string field_names [12] = '{"record_kind", "delta_time", "status_byte", "meta_type",
      "first_data", "second_data", "key_sharps", "key_minor", "time_numerator",
      "time_denominator_log2", "clocks_per_click", "thirty_seconds_per_quarter"};

   // Parser state as predicted from the accepted words.
   phase_type   parse_ph;
   logic [2:0]  tag_pos;
   logic [31:0] trk_len;
   logic [31:0] trk_used;
   logic [31:0] delta_acc;
   logic [31:0] body_len;
   logic [31:0] body_pos;
   logic [7:0]  run_status;
   logic [7:0]  cur_status;
   logic [7:0]  meta_kind;
   logic [7:0]  data_a;
   logic [7:0]  data_b;
   logic [7:0]  key_sig [2];
   logic [7:0]  time_sig [4];

   logic [7:0]       stream_q [$];
   logic [7:0]       track_body [$];
   track_record_type pending_records [$];
   int               fail_count = 0;
   int               records_seen = 0;
   int               bytes_taken = 0;
   bit               calm_stretch = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void clear_parser();
      parse_ph = PH_HUNT;
      tag_pos = '0;
      trk_len = '0;
      trk_used = '0;
      delta_acc = '0;
      body_len = '0;
      body_pos = '0;
      run_status = NO_STATUS;
      cur_status = NO_STATUS;
      meta_kind = '0;
      data_a = '0;
      data_b = '0;
      key_sig = '{default: '0};
      time_sig = '{default: '0};
   endfunction

   function automatic track_record_type make_record(logic [2:0] kind, logic [31:0] delta,
                                                    logic [7:0] status);
      track_record_type r;
      r = '{kind, delta, status, meta_kind, data_a, data_b, key_sig[0], key_sig[1],
            time_sig[0], time_sig[1], time_sig[2], time_sig[3]};
      return r;
   endfunction

   function automatic void start_hunt();
      parse_ph = PH_HUNT;
      tag_pos = '0;
   endfunction

   function automatic track_record_type close_event();
      track_record_type r;
      bit used_up;
      used_up = trk_used >= trk_len;
      r = make_record(used_up ? KIND_LEN_END : KIND_EVENT, delta_acc, cur_status);
      if (used_up) begin
         start_hunt();
      end else begin
         parse_ph = PH_DELTA;
         delta_acc = '0;
      end
      return r;
   endfunction

   // Advances the predicted parser by one word; returns 1 when a record results.
   function automatic bit parse_byte(input logic [7:0] b, output track_record_type rec);
      bit made;
      made = 1'b0;
      rec = make_record(KIND_EVENT, '0, NO_STATUS);
      if (parse_ph == PH_HUNT) begin
         if (!tag_pos[2]) begin
            if (b == TRACK_TAG[31 - 8 * tag_pos[1:0] -: 8]) begin
               tag_pos++;
            end else begin
               tag_pos = (b == MARK_M) ? 3'd1 : 3'd0;
               rec = make_record(KIND_BAD_HEADER, '0, NO_STATUS);
               made = 1'b1;
            end
         end else begin
            trk_len = {trk_len[23:0], b};
            if (tag_pos != 3'd7) begin
               tag_pos++;
            end else begin
               tag_pos = '0;
               if (trk_len == '0) begin
                  rec = make_record(KIND_EMPTY, '0, NO_STATUS);
                  made = 1'b1;
               end else begin
                  parse_ph = PH_DELTA;
                  trk_used = '0;
                  delta_acc = '0;
                  run_status = NO_STATUS;
                  cur_status = NO_STATUS;
               end
            end
         end
         return made;
      end
      if (trk_used != 32'hFFFF_FFFF) trk_used++;
      case (parse_ph)
         PH_DELTA: begin
            delta_acc = {delta_acc[24:0], b[6:0]};
            if (!b[7]) parse_ph = PH_STATUS;
         end
         PH_STATUS: begin
            if (b == STATUS_META) begin
               cur_status = b;
               parse_ph = PH_META_TYPE;
            end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
               cur_status = b;
               body_len = '0;
               parse_ph = PH_SYSEX_LEN;
            end else if (b[7] && b < STATUS_SYSEX) begin
               cur_status = b;
               run_status = b;
               parse_ph = PH_DATA1;
            end else if (!b[7] && run_status != NO_STATUS) begin
               cur_status = run_status;
               data_a = b;
               // Program change (0xCn) and channel pressure (0xDn) end here.
               if (cur_status[7:5] == 3'b110) begin
                  rec = close_event();
                  made = 1'b1;
               end else begin
                  parse_ph = PH_DATA2;
               end
            end else begin
               rec = make_record(KIND_ORPHAN, delta_acc, NO_STATUS);
               made = 1'b1;
               start_hunt();
            end
         end
         PH_DATA1: begin
            data_a = b;
            if (cur_status[7:5] == 3'b110) begin
               rec = close_event();
               made = 1'b1;
            end else begin
               parse_ph = PH_DATA2;
            end
         end
         PH_DATA2: begin
            data_b = b;
            rec = close_event();
            made = 1'b1;
         end
         PH_META_TYPE: begin
            meta_kind = b;
            body_len = '0;
            parse_ph = PH_META_LEN;
         end
         PH_META_LEN, PH_SYSEX_LEN: begin
            body_len = {body_len[24:0], b[6:0]};
            if (!b[7]) begin
               if (parse_ph == PH_META_LEN && meta_kind == META_END_TRACK) begin
                  rec = make_record(KIND_END_TRACK, delta_acc, cur_status);
                  made = 1'b1;
                  start_hunt();
               end else begin
                  body_pos = '0;
                  if (body_len == '0) begin
                     rec = close_event();
                     made = 1'b1;
                  end else begin
                     parse_ph = (parse_ph == PH_META_LEN) ? PH_META_BODY : PH_SYSEX_BODY;
                  end
               end
            end
         end
         PH_META_BODY, PH_SYSEX_BODY: begin
            if (parse_ph == PH_META_BODY) begin
               if (meta_kind == META_TIME_SIG && body_pos < 4)
                  time_sig[body_pos[1:0]] = b;
               else if (meta_kind == META_KEY_SIG && body_pos < 2)
                  key_sig[body_pos[0]] = b;
            end
            body_pos++;
            if (body_pos >= body_len) begin
               rec = close_event();
               made = 1'b1;
            end
         end
         default: start_hunt();
      endcase
      return made;
   endfunction

   function automatic field_set_type record_fields(track_record_type r);
      field_set_type f;
      f = '{32'(r.kind), r.delta, 32'(r.status), 32'(r.meta), 32'(r.first),
            32'(r.second), 32'(r.sharps), 32'(r.minor), 32'(r.numer),
            32'(r.denom_log2), 32'(r.clocks), 32'(r.thirty_seconds)};
      return f;
   endfunction

   function automatic void compare_record(track_record_type want, track_record_type seen);
      field_set_type w;
      field_set_type s;
      bit bad;
      w = record_fields(want);
      s = record_fields(seen);
      bad = 1'b0;
      for (int i = 0; i < 12; i++)
         if (w[i] !== s[i]) bad = 1'b1;
      if (bad) begin
         fail_count++;
         if (fail_count <= 10)
            for (int i = 0; i < 12; i++)
               if (w[i] !== s[i])
                  $display("record %0d: %s expected %h, got %h", records_seen,
                           field_names[i], w[i], s[i]);
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      track_record_type seen;
      track_record_type predicted;
      bit made;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_record_kind, rsp_delta_time, rsp_status_byte, rsp_meta_type,
                     rsp_first_data, rsp_second_data, rsp_key_sharps, rsp_key_minor,
                     rsp_time_numerator, rsp_time_denominator_log2, rsp_clocks_per_click,
                     rsp_thirty_seconds_per_quarter};
            if (pending_records.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("record %0d: none expected, got kind %0d status %h",
                           records_seen, rsp_record_kind, rsp_status_byte);
            end else begin
               compare_record(pending_records.pop_front(), seen);
            end
            records_seen++;
         end
         if (req_valid && req_ready) begin
            made = parse_byte(req_track_byte, predicted);
            if (bytes_taken < DIRECTED_ROWS && directed_rows[bytes_taken].typed) begin
               made = 1'b1;
               predicted.kind = directed_rows[bytes_taken].kind;
               predicted.delta = directed_rows[bytes_taken].delta;
               predicted.status = directed_rows[bytes_taken].status;
            end
            if (made) pending_records.push_back(predicted);
            bytes_taken++;
         end
      end
   end

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_stretch || r < 60) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void push_length(int n);
      if (n > 127) begin
         track_body.push_back({1'b1, 7'(n >> 7)});
         track_body.push_back({1'b0, 7'(n)});
      end else begin
         // A leading zero group with the continuation bit set is legal padding.
         if ($urandom_range(0, 7) == 0) track_body.push_back(8'h80);
         track_body.push_back(8'(n));
      end
   endfunction

   function automatic void push_delta();
      int n;
      n = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 5);
      for (int i = 1; i < n; i++) track_body.push_back({1'b1, 7'($urandom)});
      track_body.push_back({1'b0, 7'($urandom)});
   endfunction

   function automatic void push_header(logic [31:0] len);
      stream_q.push_back(MARK_M);
      stream_q.push_back(MARK_T);
      stream_q.push_back(MARK_R);
      stream_q.push_back(MARK_K);
      for (int i = 3; i >= 0; i--) stream_q.push_back(len[8 * i +: 8]);
   endfunction

   function automatic void append_track();
      int n_events;
      int pick;
      int blen;
      logic [7:0] chan;
      logic [7:0] mtype;
      logic [7:0] stray;
      logic [31:0] len;
      bit ended_eot;
      bit ended_orphan;
      track_body = {};
      chan = NO_STATUS;
      ended_eot = 1'b0;
      ended_orphan = 1'b0;
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom));
      if ($urandom_range(0, 19) == 0) begin
         push_header('0);
         return;
      end
      n_events = $urandom_range(1, 12);
      for (int k = 0; k < n_events && !ended_orphan; k++) begin
         push_delta();
         pick = $urandom_range(0, 99);
         if (pick < 25 && chan != NO_STATUS) begin
            // Running status: the word in status position is already data.
            track_body.push_back(8'($urandom_range(0, 127)));
            if (chan[7:5] != 3'b110) track_body.push_back(8'($urandom));
         end else if (pick < 50) begin
            chan = 8'($urandom_range(CHANNEL_LOW, CHANNEL_HIGH));
            track_body.push_back(chan);
            track_body.push_back(8'($urandom));
            if (chan[7:5] != 3'b110) track_body.push_back(8'($urandom));
         end else if (pick < 75) begin
            case ($urandom_range(0, 4))
               0: begin mtype = META_TIME_SIG; blen = 4; end
               1: begin mtype = META_KEY_SIG; blen = 2; end
               2: begin mtype = META_TEMPO; blen = 3; end
               3: begin mtype = META_INSTRUMENT; blen = $urandom_range(0, 6); end
               default: begin
                  mtype = 8'($urandom);
                  if (mtype == META_END_TRACK) mtype = META_TEMPO;
                  blen = $urandom_range(0, 4);
               end
            endcase
            if ($urandom_range(0, 4) == 0) blen = $urandom_range(0, 6);
            if ($urandom_range(0, 49) == 0) blen = 130;
            track_body.push_back(STATUS_META);
            track_body.push_back(mtype);
            push_length(blen);
            repeat (blen) track_body.push_back(8'($urandom));
         end else if (pick < 95) begin
            track_body.push_back($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE);
            blen = $urandom_range(0, 5);
            push_length(blen);
            repeat (blen) track_body.push_back(8'($urandom));
         end else begin
            if (chan == NO_STATUS && $urandom_range(0, 1)) begin
               track_body.push_back(8'($urandom_range(0, 127)));
            end else begin
               do stray = 8'($urandom_range(STRAY_LOW, STRAY_HIGH));
               while (stray == STATUS_ESCAPE);
               track_body.push_back(stray);
            end
            ended_orphan = 1'b1;
         end
      end
      if (!ended_orphan && $urandom_range(0, 1)) begin
         push_delta();
         track_body.push_back(STATUS_META);
         track_body.push_back(META_END_TRACK);
         push_length(0);
         ended_eot = 1'b1;
      end
      blen = track_body.size();
      pick = $urandom_range(0, 19);
      if (ended_eot || ended_orphan)
         len = (pick < 10) ? blen : (pick < 18) ? blen + $urandom_range(1, 50) : '1;
      else
         len = (pick < 15) ? blen : (pick < 19) ? $urandom_range(1, blen)
                                               : blen + $urandom_range(1, 3);
      push_header(len);
      foreach (track_body[i]) stream_q.push_back(track_body[i]);
   endfunction

   task automatic send_stream();
      int gap;
      foreach (stream_q[i]) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_track_byte <= stream_q[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) calm_stretch <= !calm_stretch;
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_track_byte = '0;
      clear_parser();
      foreach (directed_rows[i]) stream_q.push_back(directed_rows[i].track_byte);
      while (stream_q.size() < DIRECTED_ROWS + RANDOM_WORDS) append_track();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_stream();
      while (pending_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
